@@ hdl/sidasc_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII unit.
// Depends on nothing; used by every module of the unit.
`default_nettype none

package sidasc_pkg;

	localparam int VALUE_BITS_DEFAULT = 32;
	localparam int DIGIT_W            = 4;
	localparam int CHAR_W             = 6;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	typedef enum logic [1:0] {
		T_IDLE,
		T_CONV,
		T_EMIT
	} top_state_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_SIGN,
		E_DIGITS
	} emit_state_t;

	typedef struct packed {
		logic load;
		logic negative;
	} emit_cmd_t;

endpackage

`default_nettype wire

@@ hdl/sidasc_dabble.sv @@
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on sidasc_pkg for the digit width.
`default_nettype none

module sidasc_dabble #(
	parameter int VALUE_BITS = sidasc_pkg::VALUE_BITS_DEFAULT,
	parameter int DIGITS     = 10
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  load,
	input  wire logic [VALUE_BITS-1:0]                 magnitude,
	output logic      [DIGITS*sidasc_pkg::DIGIT_W-1:0] bcd,
	output logic                                       done
);

	localparam int BcdW = DIGITS * sidasc_pkg::DIGIT_W;
	localparam int CntW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	logic [VALUE_BITS-1:0] mag_q;
	logic [BcdW-1:0]       bcd_q;
	logic [BcdW-1:0]       adj;
	logic [CntW-1:0]       cnt_q;
	logic                  active_q;
	logic                  done_q;
	logic                  final_bit;

	assign final_bit = (cnt_q == CntW'(VALUE_BITS - 1));

	always_comb begin
		logic [sidasc_pkg::DIGIT_W-1:0] d;
		for (int i = 0; i < DIGITS; i++) begin
			d = bcd_q[i*sidasc_pkg::DIGIT_W +: sidasc_pkg::DIGIT_W];
			adj[i*sidasc_pkg::DIGIT_W +: sidasc_pkg::DIGIT_W] =
				(d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= active_q && final_bit;
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (final_bit)
					active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= magnitude;
			bcd_q <= '0;
		end else if (active_q) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {adj[BcdW-2:0], mag_q[VALUE_BITS-1]};
		end
	end

	assign bcd  = bcd_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ hdl/sidasc_emit.sv @@
// Character emitter: shifts BCD digits out most significant first, drops
// leading zeros and prefixes a minus sign. Depends on sidasc_pkg.
`default_nettype none

module sidasc_emit #(
	parameter int DIGITS = 10
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire sidasc_pkg::emit_cmd_t                 cmd,
	input  wire logic [DIGITS*sidasc_pkg::DIGIT_W-1:0] bcd,
	output logic                                       idle,
	output logic                                       strobe,
	output logic      [sidasc_pkg::CHAR_W-1:0]         character,
	output logic                                       last
);

	localparam int BcdW = DIGITS * sidasc_pkg::DIGIT_W;
	localparam int RemW = $clog2(DIGITS + 1);

	sidasc_pkg::emit_state_t state_q, state_d;

	logic [BcdW-1:0]                 digits_q;
	logic [RemW-1:0]                 rem_q;
	logic                            seen_q;
	logic [sidasc_pkg::DIGIT_W-1:0]  top_digit;
	logic                            final_digit;
	logic                            emit_valid;
	logic                            emit_last;
	logic                            shift;
	logic [sidasc_pkg::CHAR_W-1:0]   emit_char;
	logic                            strobe_q;
	logic                            last_q;
	logic [sidasc_pkg::CHAR_W-1:0]   char_q;

	assign top_digit   = digits_q[BcdW-1 -: sidasc_pkg::DIGIT_W];
	assign final_digit = (rem_q == RemW'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			sidasc_pkg::E_IDLE: begin
				if (cmd.load)
					state_d = cmd.negative ? sidasc_pkg::E_SIGN : sidasc_pkg::E_DIGITS;
			end
			sidasc_pkg::E_SIGN:   state_d = sidasc_pkg::E_DIGITS;
			sidasc_pkg::E_DIGITS: begin
				if (final_digit)
					state_d = sidasc_pkg::E_IDLE;
			end
			default: state_d = sidasc_pkg::E_IDLE;
		endcase
	end

	always_comb begin
		emit_valid = 1'b0;
		emit_last  = 1'b0;
		shift      = 1'b0;
		emit_char  = sidasc_pkg::ASCII_ZERO;
		case (state_q)
			sidasc_pkg::E_IDLE: ;
			sidasc_pkg::E_SIGN: begin
				emit_valid = 1'b1;
				emit_char  = sidasc_pkg::ASCII_MINUS;
			end
			sidasc_pkg::E_DIGITS: begin
				shift      = 1'b1;
				emit_valid = seen_q || (top_digit != '0) || final_digit;
				emit_last  = final_digit;
				emit_char  = sidasc_pkg::ASCII_ZERO
				             + {{(sidasc_pkg::CHAR_W - sidasc_pkg::DIGIT_W){1'b0}}, top_digit};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sidasc_pkg::E_IDLE;
			strobe_q <= 1'b0;
			seen_q   <= 1'b0;
			rem_q    <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit_valid;
			if (cmd.load && state_q == sidasc_pkg::E_IDLE) begin
				seen_q <= 1'b0;
				rem_q  <= RemW'(DIGITS);
			end else if (shift) begin
				seen_q <= seen_q || emit_valid;
				rem_q  <= rem_q - RemW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && state_q == sidasc_pkg::E_IDLE)
			digits_q <= bcd;
		else if (shift)
			digits_q <= {digits_q[BcdW-sidasc_pkg::DIGIT_W-1:0], {sidasc_pkg::DIGIT_W{1'b0}}};
		char_q <= emit_char;
		last_q <= emit_last;
	end

	assign idle      = (state_q == sidasc_pkg::E_IDLE);
	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire

@@ hdl/signed_int_to_decimal_ascii_unit.sv @@
// Signed integer to decimal ASCII unit: top level with command control.
// Depends on sidasc_pkg, sidasc_dabble and sidasc_emit.
//
// Usage:
//   Drive value and raise start; the word is taken at a clock edge where
//   start is high and busy is low. Busy stays high until the whole text
//   has been sent.
//   Characters leave on character/last, each valid for exactly one cycle
//   while strobe is high: a minus sign for negative values, then the
//   decimal digits without leading zeros ("0" for zero). last marks the
//   final character. The receiver must take every strobed character.
//   Timing: the magnitude goes through the shift-and-add-three converter
//   one bit per cycle, then the digit shifter scans one BCD digit per
//   cycle, skipping leading zeros, after a sign step for a negative value.
//   One word is in flight at a time.
//   Reset clears all control state; the unit comes up idle with strobe low.
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
	parameter int VALUE_BITS = sidasc_pkg::VALUE_BITS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [VALUE_BITS-1:0]      value,
	output logic                                   busy,
	output logic                                   strobe,
	output logic        [sidasc_pkg::CHAR_W-1:0]   character,
	output logic                                   last
);

	localparam int Digits = VALUE_BITS * 30103 / 100000 + 1;

	sidasc_pkg::top_state_t state_q, state_d;

	logic                      accept;
	logic                      neg_q;
	logic [VALUE_BITS-1:0]     magnitude;
	logic [Digits*sidasc_pkg::DIGIT_W-1:0] bcd;
	logic                      conv_done;
	logic                      emit_idle;
	sidasc_pkg::emit_cmd_t     cmd;

	assign accept    = start && !busy;
	assign magnitude = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sidasc_pkg::T_IDLE: begin
				if (start)
					state_d = sidasc_pkg::T_CONV;
			end
			sidasc_pkg::T_CONV: begin
				if (conv_done)
					state_d = sidasc_pkg::T_EMIT;
			end
			sidasc_pkg::T_EMIT: begin
				if (emit_idle)
					state_d = sidasc_pkg::T_IDLE;
			end
			default: state_d = sidasc_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		busy         = 1'b1;
		cmd.load     = 1'b0;
		cmd.negative = neg_q;
		case (state_q)
			sidasc_pkg::T_IDLE: busy = 1'b0;
			sidasc_pkg::T_CONV: cmd.load = conv_done;
			sidasc_pkg::T_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sidasc_pkg::T_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept)
			neg_q <= value[VALUE_BITS-1];
	end

	sidasc_dabble #(
		.VALUE_BITS(VALUE_BITS),
		.DIGITS    (Digits)
	) u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.magnitude(magnitude),
		.bcd      (bcd),
		.done     (conv_done)
	);

	sidasc_emit #(
		.DIGITS(Digits)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.bcd      (bcd),
		.idle     (emit_idle),
		.strobe   (strobe),
		.character(character),
		.last     (last)
	);

endmodule

`default_nettype wire

@@ test/sidasc_text_checker.sv @@
// Checker for the signed integer to decimal ASCII unit: predicts the text of each
// accepted word and compares every strobed character against it.
// Depends on sidasc_pkg for the character width and the ASCII codes.
`timescale 1ns / 100ps

module sidasc_text_checker #(
	parameter int VALUE_BITS = sidasc_pkg::VALUE_BITS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [VALUE_BITS-1:0]      value,
	input  wire logic                              busy,
	input  wire logic                              strobe,
	input  wire logic        [sidasc_pkg::CHAR_W-1:0] character,
	input  wire logic                              last,
	output int                                     mismatches,
	output int                                     pending,
	output int                                     words,
	output int                                     chars
);

	typedef struct packed {
		logic [sidasc_pkg::CHAR_W-1:0] ch;
		logic                          fin;
	} text_char_t;

	text_char_t text_q[$];
	int n_bad   = 0;
	int n_words = 0;
	int n_chars = 0;

	assign mismatches = n_bad;
	assign words      = n_words;
	assign chars      = n_chars;

	// queue the characters of one word: sign first, then digits, most significant first
	function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
		logic [VALUE_BITS-1:0] mag;
		logic [3:0]            digit_buf [0:19];
		logic                  neg;
		int                    n;
		neg = raw[VALUE_BITS-1];
		mag = neg ? (~raw + 1'b1) : raw;
		n = 0;
		do begin
			digit_buf[n] = 4'(mag % 10);
			mag = VALUE_BITS'(mag / 10);
			n++;
		end while (mag != 0);
		if (neg)
			text_q.push_back(text_char_t'{ch: sidasc_pkg::ASCII_MINUS, fin: 1'b0});
		for (int k = n - 1; k >= 0; k--)
			text_q.push_back(text_char_t'{
				ch: sidasc_pkg::ASCII_ZERO + sidasc_pkg::CHAR_W'(digit_buf[k]),
				fin: (k == 0)});
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predict_text(value);
				n_words++;
			end
			if (strobe) begin
				n_chars++;
				if (text_q.size() == 0) begin
					$error("character: nothing expected, got %0d (last %0b)", character, last);
					n_bad++;
				end else begin
					want = text_q.pop_front();
					if (character !== want.ch) begin
						$error("character: expected %0d, got %0d", want.ch, character);
						n_bad++;
					end
					if (last !== want.fin) begin
						$error("last: expected %0b, got %0b", want.fin, last);
						n_bad++;
					end
				end
			end
		end
		pending <= text_q.size();
	end

endmodule

@@ test/tb_signed_int_to_decimal_ascii_unit.sv @@
// Testbench top for the signed integer to decimal ASCII unit: drives words with
// random sender gaps and reports the verdict. Depends on sidasc_text_checker.
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_unit;

	localparam int VB          = 32;
	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_WAIT  = 60;
	localparam int PER_PHASE   = 27;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic signed [VB-1:0] value;
	logic                 busy;
	logic                 strobe;
	logic [5:0]           character;
	logic                 last;
	int                   mismatches;
	int                   pending;
	int                   words;
	int                   chars;
	int                   quiet = 0;

	int corners [20] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
		2147483647, (-2147483647 - 1), -2147483647, 999999999, 1000000000,
		-1000000000, 1234567890, -1234567890, -5, 42};
	int idle_pct [3] = '{14, 52, 0};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	signed_int_to_decimal_ascii_unit #(.VALUE_BITS(VB)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	sidasc_text_checker #(.VALUE_BITS(VB)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.busy       (busy),
		.strobe     (strobe),
		.character  (character),
		.last       (last),
		.mismatches (mismatches),
		.pending    (pending),
		.words      (words),
		.chars      (chars)
	);

	// hold start high until the word is taken; leave it high for the next call
	task automatic send_word(input logic signed [VB-1:0] v, input int gap_pct);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			value <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("** signed_int_to_decimal_ascii_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		logic signed [VB-1:0] v;
		int unsigned          tens;
		arst_n <= 1'b0;
		start  <= 1'b0;
		value  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corners[i])
			send_word(corners[i], idle_pct[0]);

		for (int ph = 0; ph < 3; ph++) begin
			repeat (PER_PHASE) begin
				case ($urandom_range(3))
					0: v = $urandom;
					1: v = $urandom_range(0, 99);
					2: begin
						// land next to a power of ten
						tens = 1;
						repeat ($urandom_range(9)) tens = tens * 10;
						v = $signed(tens) + $signed($urandom_range(0, 2)) - 1;
					end
					default: v = $urandom_range(0, 999999);
				endcase
				if ($urandom_range(1))
					v = -v;
				send_word(v, idle_pct[ph]);
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Converted %0d words into %0d characters: corner values, then random",
			words, chars);
		$display("values of mixed size and sign under heavy, light and no sender gaps.");
		if (mismatches == 0)
			$display("** signed_int_to_decimal_ascii_unit: PASSED **");
		else
			$display("** signed_int_to_decimal_ascii_unit: FAILED **");
		$finish;
	end

endmodule
